/* sv/mst_pkg.sv */
// ----------------------------------------------------------------------------
// mst_pkg: shared types and constants of the multitouch slot tracker
// Opcodes, contact kinds, register indexes, reset values and defaults.
// ----------------------------------------------------------------------------
package mst_pkg;

  localparam int DEF_SLOT_CAPACITY = 64;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int OPCODE_W = 3;
  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 2;
  localparam int INDEX_W  = 6;
  localparam int FRAC_W   = 17;
  localparam int CFG_IDX_W = 3;
  localparam int CNT_CFG_W = 7;

  typedef logic [OPCODE_W-1:0]  opcode_t;
  typedef logic [KIND_W-1:0]    kind_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam opcode_t OP_SELECT   = 3'd0;
  localparam opcode_t OP_TRACK_ID = 3'd1;
  localparam opcode_t OP_X        = 3'd2;
  localparam opcode_t OP_Y        = 3'd3;
  localparam opcode_t OP_PRESSURE = 3'd4;
  localparam opcode_t OP_SYNC     = 3'd5;
  localparam opcode_t OP_IGNORE   = 3'd6;
  localparam opcode_t OP_SPARE    = 3'd7;

  localparam kind_t KIND_MOVE = 2'd0;
  localparam kind_t KIND_DOWN = 2'd1;
  localparam kind_t KIND_UP   = 2'd2;

  localparam cfg_idx_t REG_X_MIN     = 3'd0;
  localparam cfg_idx_t REG_X_MAX     = 3'd1;
  localparam cfg_idx_t REG_Y_MIN     = 3'd2;
  localparam cfg_idx_t REG_Y_MAX     = 3'd3;
  localparam cfg_idx_t REG_P_MIN     = 3'd4;
  localparam cfg_idx_t REG_P_MAX     = 3'd5;
  localparam cfg_idx_t REG_SLOT_CNT  = 3'd6;

  localparam logic signed [VALUE_W-1:0] RST_X_MAX = 32'sd4095;
  localparam logic signed [VALUE_W-1:0] RST_Y_MAX = 32'sd4095;
  localparam logic [CNT_CFG_W-1:0]      RST_SLOT_CNT = 7'd10;
  localparam logic [CNT_CFG_W-1:0]      ZERO_CNT_SUBST = 7'd10;

endpackage

/* sv/mst_if.sv */
// ----------------------------------------------------------------------------
// mst_if: channel interfaces of the multitouch slot tracker
// Event input, result output and register write channels.
// ----------------------------------------------------------------------------
interface mst_evt_if;
  logic                                valid;
  logic                                ready;
  logic [mst_pkg::OPCODE_W-1:0]        opcode;
  logic signed [mst_pkg::VALUE_W-1:0]  event_value;
  modport source (output valid, opcode, event_value, input ready);
  modport sink   (input valid, opcode, event_value, output ready);
endinterface

interface mst_res_if;
  logic                          valid;
  logic                          ready;
  logic [mst_pkg::KIND_W-1:0]    contact_kind;
  logic [mst_pkg::INDEX_W-1:0]   slot_index;
  logic [mst_pkg::FRAC_W-1:0]    x_fraction;
  logic [mst_pkg::FRAC_W-1:0]    y_fraction;
  logic [mst_pkg::FRAC_W-1:0]    pressure_fraction;
  logic                          last_of_report;
  modport source (output valid, contact_kind, slot_index, x_fraction, y_fraction,
                  pressure_fraction, last_of_report, input ready);
  modport sink   (input valid, contact_kind, slot_index, x_fraction, y_fraction,
                  pressure_fraction, last_of_report, output ready);
endinterface

interface mst_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [mst_pkg::CFG_IDX_W-1:0]  index;
  logic [mst_pkg::VALUE_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/multitouch_slot_tracker_top.sv */
// ----------------------------------------------------------------------------
// multitouch_slot_tracker_top: protocol B multitouch slot tracker
// Tracks per-slot contact state and reports changed slots on sync.
// ----------------------------------------------------------------------------
// Ordinary events (slot select, tracking id, x, y, pressure, ignored codes)
// are absorbed at the accept edge, and the block is ready again at once. A
// sync report walks slots 0 .. count-1 under a small sequencer, skipping
// unchanged slots; a changed slot is fetched, then for each of x, y and
// pressure the operands are set up and range-checked and, unless the check
// settles it, converted in the shared restoring divider; then the slot is
// emitted, with stalls while the result register is full and not taken.
// The divider is shared by all three components and sets the pace. Event
// input is not ready during a walk; configuration writes are always taken.
// Per-slot positions live in three memories with one write and one
// registered read port; per-entry written bits make unwritten entries read
// as zero, so no clearing pass is needed.
module multitouch_slot_tracker_top #(
  parameter int SLOT_CAPACITY = mst_pkg::DEF_SLOT_CAPACITY,
  parameter int FRACTION_BITS = mst_pkg::DEF_FRACTION_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mst_evt_if.sink     evt_i,
  mst_res_if.source   res_o,
  mst_cfg_if.sink     cfg_i
);

  localparam int SLOT_W = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
  localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);
  localparam int FW     = FRACTION_BITS + 1;
  localparam int EXT_W  = (FW > mst_pkg::FRAC_W) ? FW : mst_pkg::FRAC_W;
  localparam int ITER_W = $clog2(FRACTION_BITS + 1);
  localparam logic [FW-1:0] FRAC_ONE = FW'(1) << FRACTION_BITS;
  localparam longint FLOOR_L = ((longint'(1) << FRACTION_BITS) * 5 + 99) / 100;
  localparam logic [FW-1:0] P_FLOOR = FW'(FLOOR_L);

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PREP  = 3'd2;
  localparam logic [2:0] S_CLASS = 3'd3;
  localparam logic [2:0] S_ITER  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  // Configuration registers
  logic signed [31:0] x_min_q, x_max_q, y_min_q, y_max_q, p_min_q, p_max_q;
  logic [mst_pkg::CNT_CFG_W-1:0] slot_cnt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_min_q    <= '0;
      x_max_q    <= mst_pkg::RST_X_MAX;
      y_min_q    <= '0;
      y_max_q    <= mst_pkg::RST_Y_MAX;
      p_min_q    <= '0;
      p_max_q    <= '0;
      slot_cnt_q <= mst_pkg::RST_SLOT_CNT;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        mst_pkg::REG_X_MIN:    x_min_q <= cfg_i.data;
        mst_pkg::REG_X_MAX:    x_max_q <= cfg_i.data;
        mst_pkg::REG_Y_MIN:    y_min_q <= cfg_i.data;
        mst_pkg::REG_Y_MAX:    y_max_q <= cfg_i.data;
        mst_pkg::REG_P_MIN:    p_min_q <= cfg_i.data;
        mst_pkg::REG_P_MAX:    p_max_q <= cfg_i.data;
        mst_pkg::REG_SLOT_CNT: slot_cnt_q <= cfg_i.data[mst_pkg::CNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective slot count: zero means ten, then limit to capacity
  logic [mst_pkg::CNT_CFG_W-1:0] cnt_raw;
  logic [CNT_W-1:0]              eff_cnt;
  always_comb begin
    cnt_raw = (slot_cnt_q == '0) ? mst_pkg::ZERO_CNT_SUBST : slot_cnt_q;
    if (32'(cnt_raw) > SLOT_CAPACITY) eff_cnt = CNT_W'(SLOT_CAPACITY);
    else                              eff_cnt = CNT_W'(cnt_raw);
  end

  // Control state
  logic [2:0]         state_q;
  logic [SLOT_W-1:0]  cur_q;
  logic [CNT_W-1:0]   walk_q;
  logic [1:0]         comp_q;       // 0 x, 1 y, 2 pressure
  logic [ITER_W-1:0]  iter_q;
  logic [SLOT_CAPACITY-1:0] active_q, changed_q, down_q, up_q;
  logic [SLOT_CAPACITY-1:0] x_ok_q, y_ok_q, p_ok_q;
  logic               pend_valid_q, out_valid_q;

  // Datapath registers
  logic signed [32:0] den_q, num_q;
  logic [32:0]        rem_q;
  logic [FRACTION_BITS-1:0] quo_q;
  logic [FW-1:0]      xf_q, yf_q, pf_q;
  logic signed [31:0] x_rd_q, y_rd_q, p_rd_q;
  logic signed [31:0] x_mem [SLOT_CAPACITY];
  logic signed [31:0] y_mem [SLOT_CAPACITY];
  logic signed [31:0] p_mem [SLOT_CAPACITY];
  mst_pkg::kind_t     pend_kind_q, out_kind_q;
  logic [mst_pkg::INDEX_W-1:0] pend_idx_q, out_idx_q;
  logic [mst_pkg::FRAC_W-1:0]  pend_x_q, pend_y_q, pend_p_q;
  logic [mst_pkg::FRAC_W-1:0]  out_x_q, out_y_q, out_p_q;
  logic               out_last_q;

  logic               evt_acc;
  logic               out_free;
  logic               out_load;
  logic [SLOT_W-1:0]  walk_idx;
  logic [SLOT_W-1:0]  sel_slot;
  logic signed [32:0] sel_top;
  logic signed [31:0] cur_val, sel_lo, sel_hi;
  logic [33:0]        trial;
  logic               trial_ge;
  logic [FRACTION_BITS-1:0] quo_next;
  logic [FW-1:0]      class_frac, pf_floor;
  logic               class_done;
  logic [EXT_W-1:0]   ext_x, ext_y, ext_p;
  logic [CNT_W+mst_pkg::INDEX_W-1:0] ext_idx;
  mst_pkg::kind_t     walk_kind;

  assign evt_acc  = evt_i.valid && (state_q == S_IDLE);
  assign evt_i.ready = (state_q == S_IDLE);
  assign out_free = !out_valid_q || res_o.ready;
  assign walk_idx = walk_q[SLOT_W-1:0];
  // Move the pending result into the output register
  assign out_load = pend_valid_q && out_free &&
                    ((state_q == S_EMIT) || (state_q == S_FLUSH));

  // Clamp a slot select to 0 .. count-1
  always_comb begin
    sel_top = 33'(eff_cnt) - 33'sd1;
    if (evt_i.event_value < 0)                    sel_slot = '0;
    else if (33'(evt_i.event_value) > sel_top)    sel_slot = SLOT_W'(sel_top);
    else                                          sel_slot = SLOT_W'(evt_i.event_value);
  end

  // Operand select for the component under conversion
  always_comb begin
    unique case (comp_q)
      2'd0: begin
        cur_val = x_ok_q[walk_idx] ? x_rd_q : '0;
        sel_lo  = x_min_q;
        sel_hi  = x_max_q;
      end
      2'd1: begin
        cur_val = y_ok_q[walk_idx] ? y_rd_q : '0;
        sel_lo  = y_min_q;
        sel_hi  = y_max_q;
      end
      default: begin
        cur_val = p_ok_q[walk_idx] ? p_rd_q : '0;
        sel_lo  = p_min_q;
        sel_hi  = p_max_q;
      end
    endcase
  end

  // Range checks ahead of the divider; an empty pressure range means 1.0
  always_comb begin
    class_done = 1'b1;
    if (den_q <= 0)       class_frac = (comp_q == 2'd2) ? FRAC_ONE : '0;
    else if (num_q <= 0)  class_frac = '0;
    else if (num_q >= den_q) class_frac = FRAC_ONE;
    else begin
      class_frac = '0;
      class_done = 1'b0;
    end
  end

  // One restoring division step
  always_comb begin
    trial    = {rem_q, 1'b0};
    trial_ge = trial >= {1'b0, den_q};
    quo_next = {quo_q[FRACTION_BITS-2:0], trial_ge};
  end

  // Output formatting
  always_comb begin
    pf_floor  = (pf_q < P_FLOOR) ? P_FLOOR : pf_q;
    ext_x     = EXT_W'(xf_q);
    ext_y     = EXT_W'(yf_q);
    ext_p     = EXT_W'(pf_floor);
    ext_idx   = (CNT_W+mst_pkg::INDEX_W)'(walk_q);
    walk_kind = up_q[walk_idx]   ? mst_pkg::KIND_UP :
                down_q[walk_idx] ? mst_pkg::KIND_DOWN : mst_pkg::KIND_MOVE;
  end

  // Output valid: set on a load, drop once the transaction is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (out_load)      out_valid_q <= 1'b1;
    else if (res_o.ready)   out_valid_q <= 1'b0;
  end

  // Sequencer and slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      walk_q       <= '0;
      comp_q       <= '0;
      iter_q       <= '0;
      active_q     <= '0;
      changed_q    <= '0;
      down_q       <= '0;
      up_q         <= '0;
      x_ok_q       <= '0;
      y_ok_q       <= '0;
      p_ok_q       <= '0;
      pend_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (evt_acc) begin
            unique case (evt_i.opcode)
              mst_pkg::OP_SELECT: cur_q <= sel_slot;
              mst_pkg::OP_TRACK_ID: begin
                if (evt_i.event_value < 0) begin
                  if (active_q[cur_q]) begin
                    active_q[cur_q]  <= 1'b0;
                    up_q[cur_q]      <= 1'b1;
                    changed_q[cur_q] <= 1'b1;
                  end
                end else begin
                  active_q[cur_q]  <= 1'b1;
                  down_q[cur_q]    <= 1'b1;
                  up_q[cur_q]      <= 1'b0;
                  changed_q[cur_q] <= 1'b1;
                end
              end
              mst_pkg::OP_X: begin
                x_ok_q[cur_q]    <= 1'b1;
                changed_q[cur_q] <= 1'b1;
              end
              mst_pkg::OP_Y: begin
                y_ok_q[cur_q]    <= 1'b1;
                changed_q[cur_q] <= 1'b1;
              end
              mst_pkg::OP_PRESSURE: begin
                p_ok_q[cur_q]    <= 1'b1;
                changed_q[cur_q] <= 1'b1;
              end
              mst_pkg::OP_SYNC: begin
                walk_q  <= '0;
                state_q <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_SCAN: begin
          // Skip unchanged slots; the memories read walk_q this cycle
          if (walk_q >= eff_cnt) begin
            state_q <= S_FLUSH;
          end else if (changed_q[walk_idx]) begin
            comp_q  <= 2'd0;
            state_q <= S_PREP;
          end else begin
            walk_q <= walk_q + CNT_W'(1);
          end
        end
        S_PREP: state_q <= S_CLASS;
        S_CLASS: begin
          if (class_done) begin
            if (comp_q == 2'd2) state_q <= S_EMIT;
            else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_PREP;
            end
          end else begin
            iter_q  <= ITER_W'(FRACTION_BITS);
            state_q <= S_ITER;
          end
        end
        S_ITER: begin
          iter_q <= iter_q - ITER_W'(1);
          if (iter_q == ITER_W'(1)) begin
            if (comp_q == 2'd2) state_q <= S_EMIT;
            else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_PREP;
            end
          end
        end
        S_EMIT: begin
          // Hold while a pending result cannot move to the output register
          if (!pend_valid_q || out_free) begin
            pend_valid_q      <= 1'b1;
            changed_q[walk_idx] <= 1'b0;
            down_q[walk_idx]  <= 1'b0;
            up_q[walk_idx]    <= 1'b0;
            walk_q            <= walk_q + CNT_W'(1);
            state_q           <= S_SCAN;
          end
        end
        S_FLUSH: begin
          if (!pend_valid_q) state_q <= S_IDLE;
          else if (out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Position memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (evt_acc && (evt_i.opcode == mst_pkg::OP_X)) x_mem[cur_q] <= evt_i.event_value;
    if (evt_acc && (evt_i.opcode == mst_pkg::OP_Y)) y_mem[cur_q] <= evt_i.event_value;
    if (evt_acc && (evt_i.opcode == mst_pkg::OP_PRESSURE)) p_mem[cur_q] <= evt_i.event_value;
    x_rd_q <= x_mem[walk_idx];
    y_rd_q <= y_mem[walk_idx];
    p_rd_q <= p_mem[walk_idx];
  end

  // Shared divider and result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_PREP: begin
        den_q <= 33'(sel_hi) - 33'(sel_lo);
        num_q <= 33'(cur_val) - 33'(sel_lo);
      end
      S_CLASS: begin
        rem_q <= num_q;
        quo_q <= '0;
        if (class_done) begin
          unique case (comp_q)
            2'd0:    xf_q <= class_frac;
            2'd1:    yf_q <= class_frac;
            default: pf_q <= class_frac;
          endcase
        end
      end
      S_ITER: begin
        rem_q <= trial_ge ? 33'(trial - {1'b0, den_q}) : trial[32:0];
        quo_q <= quo_next;
        if (iter_q == ITER_W'(1)) begin
          unique case (comp_q)
            2'd0:    xf_q <= FW'(quo_next);
            2'd1:    yf_q <= FW'(quo_next);
            default: pf_q <= FW'(quo_next);
          endcase
        end
      end
      S_EMIT: begin
        if (!pend_valid_q || out_free) begin
          if (pend_valid_q) begin
            out_kind_q <= pend_kind_q;
            out_idx_q  <= pend_idx_q;
            out_x_q    <= pend_x_q;
            out_y_q    <= pend_y_q;
            out_p_q    <= pend_p_q;
            out_last_q <= 1'b0;
          end
          pend_kind_q <= walk_kind;
          pend_idx_q  <= ext_idx[mst_pkg::INDEX_W-1:0];
          pend_x_q    <= ext_x[mst_pkg::FRAC_W-1:0];
          pend_y_q    <= ext_y[mst_pkg::FRAC_W-1:0];
          pend_p_q    <= ext_p[mst_pkg::FRAC_W-1:0];
        end
      end
      S_FLUSH: begin
        if (pend_valid_q && out_free) begin
          out_kind_q <= pend_kind_q;
          out_idx_q  <= pend_idx_q;
          out_x_q    <= pend_x_q;
          out_y_q    <= pend_y_q;
          out_p_q    <= pend_p_q;
          out_last_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.contact_kind      = out_kind_q;
  assign res_o.slot_index        = out_idx_q;
  assign res_o.x_fraction        = out_x_q;
  assign res_o.y_fraction        = out_y_q;
  assign res_o.pressure_fraction = out_p_q;
  assign res_o.last_of_report    = out_last_q;

endmodule
